// ===== hdl/qtue_pkg.sv =====
// shared types, constants and row helper for the q table update engine
`timescale 1ns / 1ps

package qtue_pkg;

    localparam int ACTIONS = 4;
    localparam int ACT_W   = 2;
    localparam int VAL_W   = 32;
    localparam int LR_W    = 17;
    localparam int DISC_W  = 16;
    localparam int IDX_W   = 8;

    localparam logic [LR_W-1:0]   ALPHA_ONE  = 17'd65536;
    localparam logic [LR_W-1:0]   LR_RESET   = 17'd6554;
    localparam logic [DISC_W-1:0] DISC_RESET = 16'd62259;

    localparam logic CFG_LEARNING_RATE = 1'b0;
    localparam logic CFG_DISCOUNT      = 1'b1;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [ACTIONS-1:0][VAL_W-1:0] row_t;

    typedef struct packed {
        logic [ACT_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } greedy_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_CUR,
        ST_LOAD,
        ST_DELTA,
        ST_PROD2,
        ST_NEWVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic rd_next;
        logic take_future;
        logic load_row;
        logic delta;
        logic prod2;
        logic newval;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic out_free;
    } status_t;

    // largest entry of a row, lowest index on ties
    function automatic greedy_t row_greedy(input row_t row);
        greedy_t lo;
        greedy_t hi;
        greedy_t res;
        lo.idx = 2'd0;
        lo.val = row[0];
        if ($signed(row[1]) > $signed(row[0]))
        begin
            lo.idx = 2'd1;
            lo.val = row[1];
        end
        hi.idx = 2'd2;
        hi.val = row[2];
        if ($signed(row[3]) > $signed(row[2]))
        begin
            hi.idx = 2'd3;
            hi.val = row[3];
        end
        res = lo;
        if ($signed(hi.val) > $signed(lo.val))
        begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// ===== hdl/qtue_ctrl.sv =====
// sequencer for table clear, update and query of the q table engine
`timescale 1ns / 1ps

module qtue_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qtue_pkg::status_t status,
    output qtue_pkg::cmd_t   cmd
);

    qtue_pkg::state_t state_reg;
    qtue_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qtue_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qtue_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = qtue_pkg::ST_IDLE;
            end
            qtue_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = qtue_pkg::ST_RD_FIRST;
            end
            qtue_pkg::ST_RD_FIRST:
            begin
                if (status.is_query)
                    state_next = qtue_pkg::ST_LOAD;
                else
                    state_next = qtue_pkg::ST_RD_CUR;
            end
            qtue_pkg::ST_RD_CUR:
            begin
                state_next = qtue_pkg::ST_LOAD;
            end
            qtue_pkg::ST_LOAD:
            begin
                if (status.is_query)
                    state_next = qtue_pkg::ST_FINISH;
                else
                    state_next = qtue_pkg::ST_DELTA;
            end
            qtue_pkg::ST_DELTA:
            begin
                state_next = qtue_pkg::ST_PROD2;
            end
            qtue_pkg::ST_PROD2:
            begin
                state_next = qtue_pkg::ST_NEWVAL;
            end
            qtue_pkg::ST_NEWVAL:
            begin
                state_next = qtue_pkg::ST_FINISH;
            end
            qtue_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = qtue_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qtue_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            qtue_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            qtue_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            qtue_pkg::ST_RD_FIRST:
            begin
                cmd.rd_next = 1'b1;
            end
            qtue_pkg::ST_RD_CUR:
            begin
                cmd.take_future = 1'b1;
            end
            qtue_pkg::ST_LOAD:
            begin
                cmd.load_row = 1'b1;
            end
            qtue_pkg::ST_DELTA:
            begin
                cmd.delta = 1'b1;
            end
            qtue_pkg::ST_PROD2:
            begin
                cmd.prod2 = 1'b1;
            end
            qtue_pkg::ST_NEWVAL:
            begin
                cmd.newval = 1'b1;
            end
            qtue_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/qtue_datapath.sv =====
// value table memory, config registers, arithmetic and output register
`timescale 1ns / 1ps

module qtue_datapath
#(
    parameter int NUM_ROWS = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_index,
    input  logic [16:0]              cfg_data,
    input  logic                     opcode,
    input  logic [7:0]               state_index,
    input  logic [1:0]               action_index,
    input  logic signed [31:0]       reward,
    input  logic [7:0]               next_state_index,
    input  logic                     terminal,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [1:0]               greedy_action,
    output logic signed [31:0]       greedy_value,
    output logic signed [31:0]       updated_value,
    output logic                     saturated,
    input  qtue_pkg::cmd_t           cmd,
    output qtue_pkg::status_t        status
);

    localparam int AW = (NUM_ROWS > 2) ? $clog2(NUM_ROWS) : 1;
    localparam logic [AW-1:0] LAST_ROW = AW'(NUM_ROWS - 1);
    localparam logic [16:0] COUNT_W = 17'(NUM_ROWS);

    qtue_pkg::row_t row_mem [NUM_ROWS];

    logic                op_reg, op_next;
    logic [7:0]          s_reg, s_next;
    logic [1:0]          a_reg, a_next;
    logic signed [31:0]  reward_reg, reward_next;
    logic [7:0]          ns_reg, ns_next;
    logic                term_reg, term_next;
    logic [16:0]         lr_reg, lr_next;
    logic [15:0]         disc_reg, disc_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    qtue_pkg::row_t      rd_row_reg;
    logic signed [31:0]  future_reg, future_next;
    qtue_pkg::row_t      row_reg, row_next;
    logic signed [47:0]  prod1_reg, prod1_next;
    logic signed [33:0]  delta_reg, delta_next;
    logic signed [50:0]  prod2_reg, prod2_next;
    logic signed [31:0]  newv_reg, newv_next;
    logic                sat_reg, sat_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          gact_reg, gact_next;
    logic signed [31:0]  gval_reg, gval_next;
    logic signed [31:0]  upd_reg, upd_next;
    logic                osat_reg, osat_next;

    logic                s_in_range;
    logic                ns_in_range;
    logic [AW-1:0]       s_addr;
    logic [AW-1:0]       ns_addr;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    qtue_pkg::row_t      wr_row;
    qtue_pkg::row_t      new_row;
    qtue_pkg::row_t      out_row;
    qtue_pkg::greedy_t   next_best;
    qtue_pkg::greedy_t   out_best;
    logic signed [31:0]  cur_val;
    logic signed [47:0]  r1_full;
    logic signed [50:0]  r2_full;
    logic signed [35:0]  sum_val;
    logic [15:0]         s_ext;
    logic [15:0]         ns_ext;

    assign s_ext       = {8'd0, s_reg};
    assign ns_ext      = {8'd0, ns_reg};
    assign s_addr      = s_ext[AW-1:0];
    assign ns_addr     = ns_ext[AW-1:0];
    assign s_in_range  = {9'd0, s_reg} < COUNT_W;
    assign ns_in_range = {9'd0, ns_reg} < COUNT_W;
    assign rd_addr     = (cmd.rd_next && (op_reg == qtue_pkg::OP_UPDATE)) ? ns_addr : s_addr;

    assign cur_val   = $signed(row_reg[a_reg]);
    assign next_best = qtue_pkg::row_greedy(rd_row_reg);

    // round half up: add half an lsb then arithmetic shift
    assign r1_full = (prod1_reg + 48'sd32768) >>> 16;
    assign r2_full = (prod2_reg + 51'sd32768) >>> 16;
    assign sum_val = 36'($signed(r2_full[34:0])) + 36'(cur_val);

    always_comb
    begin
        new_row = row_reg;
        if (!status.is_query)
            new_row[a_reg] = newv_reg;
    end

    assign out_row  = s_in_range ? new_row : '0;
    assign out_best = qtue_pkg::row_greedy(out_row);

    assign mem_we  = cmd.clear || (cmd.finish && !status.is_query && s_in_range);
    assign wr_addr = cmd.clear ? clr_cnt_reg : s_addr;
    assign wr_row  = cmd.clear ? '0 : new_row;

    assign status.clear_last = (clr_cnt_reg == LAST_ROW);
    assign status.is_query   = (op_reg == qtue_pkg::OP_QUERY);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[wr_addr] <= wr_row;
        rd_row_reg <= row_mem[rd_addr];
    end

    always_comb
    begin
        op_next     = op_reg;
        s_next      = s_reg;
        a_next      = a_reg;
        reward_next = reward_reg;
        ns_next     = ns_reg;
        term_next   = term_reg;
        if (cmd.capture)
        begin
            op_next     = opcode;
            s_next      = state_index;
            a_next      = action_index;
            reward_next = reward;
            ns_next     = next_state_index;
            term_next   = terminal;
        end
    end

    always_comb
    begin
        lr_next   = lr_reg;
        disc_next = disc_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                qtue_pkg::CFG_LEARNING_RATE:
                begin
                    // alpha above one acts as one
                    lr_next = (cfg_data > qtue_pkg::ALPHA_ONE) ? qtue_pkg::ALPHA_ONE : cfg_data;
                end
                qtue_pkg::CFG_DISCOUNT:
                begin
                    disc_next = cfg_data[15:0];
                end
                default:
                begin
                    lr_next = lr_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
            clr_cnt_next = clr_cnt_reg + 1'b1;
    end

    always_comb
    begin
        future_next = future_reg;
        row_next    = row_reg;
        prod1_next  = prod1_reg;
        delta_next  = delta_reg;
        prod2_next  = prod2_reg;
        newv_next   = newv_reg;
        sat_next    = sat_reg;
        if (cmd.take_future)
            future_next = (term_reg || !ns_in_range) ? 32'sd0 : $signed(next_best.val);
        if (cmd.load_row)
        begin
            row_next   = s_in_range ? rd_row_reg : '0;
            prod1_next = 48'(future_reg) * 48'($signed({1'b0, disc_reg}));
        end
        if (cmd.delta)
            delta_next = 34'(reward_reg) + 34'($signed(r1_full[31:0])) - 34'(cur_val);
        if (cmd.prod2)
            prod2_next = 51'(delta_reg) * 51'($signed({1'b0, lr_reg}));
        if (cmd.newval)
        begin
            sat_next  = 1'b0;
            newv_next = $signed(sum_val[31:0]);
            if (sum_val > 36'sd2147483647)
            begin
                newv_next = 32'sh7fffffff;
                sat_next  = 1'b1;
            end
            else if (sum_val < -36'sd2147483648)
            begin
                newv_next = 32'sh80000000;
                sat_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        gact_next      = gact_reg;
        gval_next      = gval_reg;
        upd_next       = upd_reg;
        osat_next      = osat_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            gact_next      = out_best.idx;
            gval_next      = $signed(out_best.val);
            upd_next       = status.is_query ? 32'sd0 : newv_reg;
            osat_next      = status.is_query ? 1'b0 : sat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        s_reg      <= s_next;
        a_reg      <= a_next;
        reward_reg <= reward_next;
        ns_reg     <= ns_next;
        term_reg   <= term_next;
        future_reg <= future_next;
        row_reg    <= row_next;
        prod1_reg  <= prod1_next;
        delta_reg  <= delta_next;
        prod2_reg  <= prod2_next;
        newv_reg   <= newv_next;
        sat_reg    <= sat_next;
        gact_reg   <= gact_next;
        gval_reg   <= gval_next;
        upd_reg    <= upd_next;
        osat_reg   <= osat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= qtue_pkg::LR_RESET;
            disc_reg      <= qtue_pkg::DISC_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lr_reg        <= lr_next;
            disc_reg      <= disc_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign greedy_action = gact_reg;
    assign greedy_value  = gval_reg;
    assign updated_value = upd_reg;
    assign saturated     = osat_reg;

endmodule

// ===== hdl/q_table_update_engine_unit.sv =====
// top level of the q table update engine: sequencer, datapath and checks
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    opcode, states, action, reward, terminal
//   out      output     out_valid/out_ready  greedy action and value, new value, clamp
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// update takes 8 cycles from accept to the next accept, query 4, set by the
// single read port of the table and the two chained multiplies
// after reset the table is zeroed one row a cycle, NUM_ROWS cycles, with in_ready low
// a result waiting in the output register stalls the block only at its last step
// cfg is always ready and may be written while idle
`timescale 1ns / 1ps

module q_table_update_engine_unit
#(
    parameter int NUM_ROWS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [7:0]         state_index,
    input  logic [1:0]         action_index,
    input  logic signed [31:0] reward,
    input  logic [7:0]         next_state_index,
    input  logic               terminal,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         greedy_action,
    output logic signed [31:0] greedy_value,
    output logic signed [31:0] updated_value,
    output logic               saturated
);

    qtue_pkg::cmd_t    cmd;
    qtue_pkg::status_t status;

    assign cfg_ready = 1'b1;

    qtue_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    qtue_datapath
    #(
        .NUM_ROWS (NUM_ROWS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .opcode           (opcode),
        .state_index      (state_index),
        .action_index     (action_index),
        .reward           (reward),
        .next_state_index (next_state_index),
        .terminal         (terminal),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .greedy_action    (greedy_action),
        .greedy_value     (greedy_value),
        .updated_value    (updated_value),
        .saturated        (saturated),
        .cmd              (cmd),
        .status           (status)
    );

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while another is in flight");

    // no word taken during the table clear
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !in_ready)
        else $error("input ready during table clear");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result overwritten before it was taken");

    // finishing presents a result
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished item produced no result");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the q table update engine with a queue-fed driver and monitor
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ROWS        = 256;
    localparam int SHOW_MAX    = 10;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    typedef struct {
        logic               op;
        logic [7:0]         s;
        logic [1:0]         a;
        logic signed [31:0] rwd;
        logic [7:0]         ns;
        logic               term;
    } transition_t;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] best;
        logic signed [31:0] newv;
        logic               sat;
    } q_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = qtue_pkg::CFG_LEARNING_RATE;
    logic [16:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = qtue_pkg::OP_UPDATE;
    logic [7:0]         state_index = '0;
    logic [1:0]         action_index = '0;
    logic signed [31:0] reward = '0;
    logic [7:0]         next_state_index = '0;
    logic               terminal = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         greedy_action;
    logic signed [31:0] greedy_value;
    logic signed [31:0] updated_value;
    logic               saturated;

    // predictor copy of the table and registers
    logic signed [31:0] q_shadow [ROWS][qtue_pkg::ACTIONS];
    logic [qtue_pkg::LR_W-1:0]   lr_now = qtue_pkg::LR_RESET;
    logic [qtue_pkg::DISC_W-1:0] disc_now = qtue_pkg::DISC_RESET;

    transition_t transitions_todo[$];
    q_result_t   results_due[$];
    transition_t drv_item;
    transition_t seen_item;
    q_result_t   due;

    bit          in_took = 1'b0;
    bit          gaps_on = 1'b1;
    int          send_gap = 0;
    int          recv_gap = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    q_table_update_engine_unit u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .state_index      (state_index),
        .action_index     (action_index),
        .reward           (reward),
        .next_state_index (next_state_index),
        .terminal         (terminal),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .greedy_action    (greedy_action),
        .greedy_value     (greedy_value),
        .updated_value    (updated_value),
        .saturated        (saturated)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        foreach (q_shadow[i, j])
        begin
            q_shadow[i][j] = '0;
        end
    end

    task automatic best_in_row(input logic [7:0] s, output logic [1:0] idx,
                               output logic signed [31:0] v);
        idx = 2'd0;
        v = q_shadow[s][0];
        for (int a = 1; a < qtue_pkg::ACTIONS; a++)
        begin
            if (q_shadow[s][a] > v)
            begin
                v = q_shadow[s][a];
                idx = a[1:0];
            end
        end
    endtask

    // bellman update and greedy readback for one accepted word
    task automatic q_learn_step(input transition_t t);
        longint             alpha;
        longint             cur;
        longint             fut;
        longint             tgt;
        longint             dlt;
        longint             nv;
        logic [1:0]         idx;
        logic signed [31:0] v;
        q_result_t          r;
        nv = 0;
        r.sat = 1'b0;
        if (t.op == qtue_pkg::OP_UPDATE)
        begin
            alpha = (lr_now > qtue_pkg::ALPHA_ONE) ? longint'(qtue_pkg::ALPHA_ONE)
                                                   : longint'(lr_now);
            cur = q_shadow[t.s][t.a];
            fut = 0;
            if (!t.term)
            begin
                best_in_row(t.ns, idx, v);
                fut = v;
            end
            tgt = longint'(t.rwd) + ((fut * longint'(disc_now) + 64'sd32768) >>> 16);
            dlt = tgt - cur;
            nv = cur + ((dlt * alpha + 64'sd32768) >>> 16);
            if (nv > VAL_MAX)
            begin
                nv = VAL_MAX;
                r.sat = 1'b1;
            end
            else if (nv < VAL_MIN)
            begin
                nv = VAL_MIN;
                r.sat = 1'b1;
            end
            q_shadow[t.s][t.a] = nv[31:0];
        end
        best_in_row(t.s, idx, v);
        r.act = idx;
        r.best = v;
        r.newv = nv[31:0];
        results_due = {results_due, r};
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (transitions_todo.size() > 0)
            begin
                drv_item = transitions_todo.pop_front();
                opcode           <= drv_item.op;
                state_index      <= drv_item.s;
                action_index     <= drv_item.a;
                reward           <= drv_item.rwd;
                next_state_index <= drv_item.ns;
                terminal         <= drv_item.term;
                in_valid         <= 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0)
                begin
                    send_gap = $urandom_range(1, 13);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            in_took = rst_n && in_valid && in_ready;
            if (rst_n && cfg_valid && cfg_ready)
            begin
                if (cfg_index == qtue_pkg::CFG_LEARNING_RATE)
                begin
                    lr_now = cfg_data;
                end
                else
                begin
                    disc_now = cfg_data[qtue_pkg::DISC_W-1:0];
                end
            end
            if (rst_n && out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                    begin
                        $display("unexpected word: act %0d best %0d new %0d sat %0b",
                                 greedy_action, greedy_value, updated_value, saturated);
                    end
                end
                else
                begin
                    due = results_due.pop_front();
                    if (greedy_action !== due.act || greedy_value !== due.best ||
                        updated_value !== due.newv || saturated !== due.sat)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                        begin
                            $display("mismatch: exp act %0d best %0d new %0d sat %0b",
                                     due.act, due.best, due.newv, due.sat);
                            $display("          got act %0d best %0d new %0d sat %0b",
                                     greedy_action, greedy_value, updated_value, saturated);
                        end
                    end
                end
            end
            if (in_took)
            begin
                seen_item.op   = opcode;
                seen_item.s    = state_index;
                seen_item.a    = action_index;
                seen_item.rwd  = reward;
                seen_item.ns   = next_state_index;
                seen_item.term = terminal;
                q_learn_step(seen_item);
            end
        end
    end

    task automatic add_item(input logic op, input logic [7:0] s, input logic [1:0] a,
                            input logic signed [31:0] rwd, input logic [7:0] ns,
                            input logic term);
        transition_t t;
        t.op = op;
        t.s = s;
        t.a = a;
        t.rwd = rwd;
        t.ns = ns;
        t.term = term;
        transitions_todo = {transitions_todo, t};
    endtask

    // mostly updates on a small set of rows so values build up toward the limits
    task automatic add_random_items(input int n);
        logic               op;
        logic [7:0]         s;
        logic [7:0]         ns;
        logic signed [31:0] rwd;
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(0, 3) == 0) ? qtue_pkg::OP_QUERY : qtue_pkg::OP_UPDATE;
            s  = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            ns = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0: rwd = 32'sh7fffffff;
                1: rwd = 32'sh80000000;
                2: rwd = $urandom_range(0, 1 << 20) - (1 << 19);
                default: rwd = $urandom();
            endcase
            add_item(op, s, 2'($urandom_range(0, 3)), rwd, ns, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        @(posedge clk);
        while (transitions_todo.size() > 0 || in_valid || results_due.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [16:0] lr, input logic [15:0] disc,
                             input int n, input bit gaps);
        write_reg(qtue_pkg::CFG_LEARNING_RATE, lr);
        write_reg(qtue_pkg::CFG_DISCOUNT, {1'b0, disc});
        gaps_on = gaps;
        add_random_items(n);
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // table clear runs with in_ready low
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end

        write_reg(qtue_pkg::CFG_LEARNING_RATE, qtue_pkg::ALPHA_ONE);
        write_reg(qtue_pkg::CFG_DISCOUNT, 17'd65535);
        add_item(qtue_pkg::OP_QUERY,  8'd0,   2'd0, 32'sd0,        8'd0,   1'b0);
        add_item(qtue_pkg::OP_UPDATE, 8'd0,   2'd3, 32'sh7fffffff, 8'd9,   1'b1);
        add_item(qtue_pkg::OP_UPDATE, 8'd1,   2'd2, 32'sh7fffffff, 8'd0,   1'b0);
        add_item(qtue_pkg::OP_QUERY,  8'd1,   2'd0, 32'sd0,        8'd0,   1'b0);
        for (int a = 0; a < qtue_pkg::ACTIONS; a++)
        begin
            add_item(qtue_pkg::OP_UPDATE, 8'd4, 2'(a), 32'sh80000000, 8'd9, 1'b1);
        end
        add_item(qtue_pkg::OP_UPDATE, 8'd5,   2'd1, 32'sh80000000, 8'd4,   1'b0);
        add_item(qtue_pkg::OP_UPDATE, 8'd6,   2'd1, 32'sh00050000, 8'd9,   1'b1);
        add_item(qtue_pkg::OP_UPDATE, 8'd6,   2'd2, 32'sh00050000, 8'd9,   1'b1);
        add_item(qtue_pkg::OP_QUERY,  8'd6,   2'd3, 32'sh7fffffff, 8'd255, 1'b1);
        add_item(qtue_pkg::OP_UPDATE, 8'd7,   2'd0, 32'sd100,      8'd0,   1'b1);
        add_item(qtue_pkg::OP_UPDATE, 8'd255, 2'd3, 32'sd1,        8'd255, 1'b0);
        add_item(qtue_pkg::OP_QUERY,  8'd255, 2'd0, 32'sd0,        8'd0,   1'b0);
        add_item(qtue_pkg::OP_UPDATE, 8'd8,   2'd2, -32'sd1,       8'd6,   1'b0);
        add_item(qtue_pkg::OP_UPDATE, 8'd0,   2'd3, 32'sh7fffffff, 8'd1,   1'b0);
        drain();

        // alpha zero keeps the entry
        write_reg(qtue_pkg::CFG_LEARNING_RATE, 17'd0);
        write_reg(qtue_pkg::CFG_DISCOUNT, 17'd0);
        add_item(qtue_pkg::OP_UPDATE, 8'd0, 2'd3, 32'sh80000000, 8'd0, 1'b1);
        add_item(qtue_pkg::OP_UPDATE, 8'd4, 2'd0, 32'sh7fffffff, 8'd0, 1'b0);
        add_item(qtue_pkg::OP_QUERY,  8'd0, 2'd1, 32'sd0,        8'd0, 1'b0);
        drain();

        run_phase(17'd131071, 16'd32768, 300, 1'b1);
        run_phase(17'd1, 16'd65535, 250, 1'b0);
        run_phase(qtue_pkg::LR_RESET, qtue_pkg::DISC_RESET, 350, 1'b1);
        run_phase(qtue_pkg::ALPHA_ONE, 16'd0, 250, 1'b1);
        run_phase(17'($urandom_range(0, 131071)), 16'($urandom_range(0, 65535)), 250, 1'b1);
        run_phase(17'd98304, 16'd65535, 300, 1'b1);
        run_phase(17'd32768, 16'd58982, 300, 1'b0);

        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
